[rtl/cpt_pkg.sv]
`timescale 1ns / 1ps
package cpt_pkg;

	// Barycentric weights are unsigned Q1.30.
	localparam int WEIGHT_W = 31;
	localparam int Q_FRAC = 30;
	localparam int REGION_W = 3;

	// Digit width of the multi-cycle determinant multiplier.
	localparam int MUL_DIG = 17;

	typedef logic [WEIGHT_W-1:0] weight_t;
	typedef logic [REGION_W-1:0] region_t;

	localparam weight_t W_ONE = weight_t'(1) << Q_FRAC;

	localparam region_t RG_A  = 3'd0;
	localparam region_t RG_B  = 3'd1;
	localparam region_t RG_AB = 3'd2;
	localparam region_t RG_C  = 3'd3;
	localparam region_t RG_AC = 3'd4;
	localparam region_t RG_BC = 3'd5;
	localparam region_t RG_IN = 3'd6;

endpackage

[rtl/cpt_if.sv]
`timescale 1ns / 1ps
interface cpt_in_if #(
	parameter int COORD_BITS = 32
);
	logic valid;
	logic ready;
	logic signed [COORD_BITS-1:0] query_x;
	logic signed [COORD_BITS-1:0] query_y;
	logic signed [COORD_BITS-1:0] query_z;
	logic signed [COORD_BITS-1:0] corner_a_x;
	logic signed [COORD_BITS-1:0] corner_a_y;
	logic signed [COORD_BITS-1:0] corner_a_z;
	logic signed [COORD_BITS-1:0] corner_b_x;
	logic signed [COORD_BITS-1:0] corner_b_y;
	logic signed [COORD_BITS-1:0] corner_b_z;
	logic signed [COORD_BITS-1:0] corner_c_x;
	logic signed [COORD_BITS-1:0] corner_c_y;
	logic signed [COORD_BITS-1:0] corner_c_z;

	modport source (
		output valid, query_x, query_y, query_z,
		output corner_a_x, corner_a_y, corner_a_z,
		output corner_b_x, corner_b_y, corner_b_z,
		output corner_c_x, corner_c_y, corner_c_z,
		input ready
	);
	modport sink (
		input valid, query_x, query_y, query_z,
		input corner_a_x, corner_a_y, corner_a_z,
		input corner_b_x, corner_b_y, corner_b_z,
		input corner_c_x, corner_c_y, corner_c_z,
		output ready
	);
endinterface

interface cpt_out_if #(
	parameter int COORD_BITS = 32
);
	logic valid;
	logic ready;
	logic signed [COORD_BITS-1:0] near_x;
	logic signed [COORD_BITS-1:0] near_y;
	logic signed [COORD_BITS-1:0] near_z;
	logic [30:0] weight_a;
	logic [30:0] weight_b;
	logic [30:0] weight_c;
	logic [2:0] region;
	logic degenerate;

	modport source (
		output valid, near_x, near_y, near_z, weight_a, weight_b, weight_c,
		output region, degenerate,
		input ready
	);
	modport sink (
		input valid, near_x, near_y, near_z, weight_a, weight_b, weight_c,
		input region, degenerate,
		output ready
	);
endinterface

[rtl/cpt_dly.sv]
`timescale 1ns / 1ps
module cpt_dly #(
	parameter int W = 8,
	parameter int N = 1
) (
	input  logic         clk,
	input  logic         en,
	input  logic [W-1:0] d,
	output logic [W-1:0] q
);

	logic [W-1:0] line_s [N];

	always_ff @(posedge clk) begin
		if (en) begin
			line_s[0] <= d;
			for (int i = 1; i < N; i++) begin
				line_s[i] <= line_s[i-1];
			end
		end
	end

	assign q = line_s[N-1];

endmodule

[rtl/cpt_mul.sv]
`timescale 1ns / 1ps
module cpt_mul
	import cpt_pkg::*;
#(
	parameter int AW = 68,
	parameter int BW = 68
) (
	input  logic                    clk,
	input  logic                    en,
	input  logic signed [AW-1:0]    a,
	input  logic signed [BW-1:0]    b,
	output logic signed [AW+BW-1:0] p
);

	localparam int NST = (BW + MUL_DIG - 1) / MUL_DIG;
	localparam int BPW = NST * MUL_DIG;
	localparam int PW = AW + BW;

	logic signed [AW-1:0]        a_s   [NST];
	logic signed [BPW-1:0]       b_s   [NST];
	logic signed [PW-1:0]        acc_s [NST];
	logic signed [AW-1:0]        a_in  [NST];
	logic signed [BPW-1:0]       b_in  [NST];
	logic signed [PW-1:0]        acc_in[NST];
	logic signed [MUL_DIG:0]     dig   [NST];
	logic signed [AW+MUL_DIG:0]  part  [NST];

	// One digit of b per stage; only the top digit carries the sign.
	always_comb begin
		for (int k = 0; k < NST; k++) begin
			if (k == 0) begin
				a_in[k] = a;
				b_in[k] = BPW'(b);
				acc_in[k] = '0;
			end else begin
				a_in[k] = a_s[k-1];
				b_in[k] = b_s[k-1];
				acc_in[k] = acc_s[k-1];
			end
			dig[k] = $signed({(k == NST - 1) ? b_in[k][BPW-1] : 1'b0,
				b_in[k][k*MUL_DIG +: MUL_DIG]});
			part[k] = a_in[k] * dig[k];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < NST; k++) begin
				a_s[k] <= a_in[k];
				b_s[k] <= b_in[k];
				acc_s[k] <= acc_in[k] + (PW'(part[k]) <<< (k * MUL_DIG));
			end
		end
	end

	assign p = acc_s[NST-1];

endmodule

[rtl/cpt_div.sv]
`timescale 1ns / 1ps
module cpt_div
	import cpt_pkg::*;
#(
	parameter int NW = 140
) (
	input  logic                 clk,
	input  logic                 en,
	input  logic signed [NW-1:0] num,
	input  logic signed [NW-1:0] den,
	output weight_t              q
);

	localparam logic [1:0] SAT_RUN  = 2'd0;
	localparam logic [1:0] SAT_ZERO = 2'd1;
	localparam logic [1:0] SAT_ONE  = 2'd2;

	logic [NW-1:0]     den_s [Q_FRAC+1];
	logic [NW-1:0]     rem_s [Q_FRAC];
	logic [Q_FRAC-1:0] quo_s [Q_FRAC+1];
	logic [1:0]        sat_s [Q_FRAC+1];
	logic [NW:0]       trial [Q_FRAC];
	logic signed [NW:0] diff;

	assign diff = (NW+1)'(num) - (NW+1)'(den);

	// Restoring division, one quotient bit per stage. The remainder stays below den.
	always_comb begin
		for (int k = 0; k < Q_FRAC; k++) begin
			trial[k] = {rem_s[k], 1'b0} - {den_s[k][NW-1], den_s[k]};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			den_s[0] <= den;
			rem_s[0] <= num;
			quo_s[0] <= '0;
			if (num[NW-1] || num == '0) begin
				sat_s[0] <= SAT_ZERO;
			end else if (!diff[NW]) begin
				sat_s[0] <= SAT_ONE;
			end else begin
				sat_s[0] <= SAT_RUN;
			end
			for (int k = 0; k < Q_FRAC; k++) begin
				den_s[k+1] <= den_s[k];
				sat_s[k+1] <= sat_s[k];
				quo_s[k+1] <= {quo_s[k][Q_FRAC-2:0], !trial[k][NW]};
				if (k < Q_FRAC - 1) begin
					rem_s[k+1] <= trial[k][NW] ? {rem_s[k][NW-2:0], 1'b0} : trial[k][NW-1:0];
				end
			end
		end
	end

	always_comb begin
		case (sat_s[Q_FRAC])
			SAT_ZERO: q = '0;
			SAT_ONE:  q = W_ONE;
			default:  q = WEIGHT_W'(quo_s[Q_FRAC]);
		endcase
	end

endmodule

[rtl/closest_point_on_triangle_top.sv]
`timescale 1ns / 1ps
// Closest point on a triangle, fully pipelined, one item accepted per clock unless the output stalls.
// The 31-stage Q1.30 divider and the digit-per-stage determinant multipliers set the
// pipeline depth, which grows with COORD_BITS.
// Throughput is one item per cycle; while a result waits the whole pipeline holds.
// Reset (arst_n low, asynchronous) clears every valid bit; data registers are not reset.
module closest_point_on_triangle_top
	import cpt_pkg::*;
#(
	parameter int COORD_BITS = 32
) (
	input logic       clk,
	input logic       arst_n,
	cpt_in_if.sink    req,
	cpt_out_if.source rsp
);

	localparam int CB = COORD_BITS;
	localparam int DW = CB + 1;                // coordinate difference
	localparam int PW = 2 * DW;                // one product of differences
	localparam int DOTW = PW + 2;              // dot product of an edge and a query offset
	localparam int DETW = 2 * DOTW + 1;        // 2x2 region determinant
	localparam int NW = DETW + 2;              // divider operand, sum of three determinants
	localparam int NM = (DOTW + MUL_DIG - 1) / MUL_DIG;
	localparam int DIV_LAT = Q_FRAC + 1;
	localparam int LAT = 8 + NM + DIV_LAT;
	localparam int SIDE_N = 4 + NM + DIV_LAT;
	localparam int SW = 9 * CB + 9 * DW;
	localparam int MW = DW + WEIGHT_W + 1;
	localparam int MUL_A [6] = '{0, 2, 4, 0, 2, 4};
	localparam int MUL_B [6] = '{3, 1, 1, 5, 5, 3};

	// The pipeline moves as one. The valid chain marks which stages hold an item.
	logic           adv;
	logic [LAT-1:0] vld_q;

	assign adv = !vld_q[LAT-1] || rsp.ready;
	assign req.ready = adv;
	assign rsp.valid = vld_q[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[LAT-2:0], req.valid};
		end
	end

	// Stage 1: differences. Index 0 is the query point, then the corners A, B and C.
	logic signed [CB-1:0] crn_in [4][3];
	logic signed [CB-1:0] crn_s1 [3][3];
	logic signed [DW-1:0] fv_s1 [3][3];      // P-A, P-B, P-C
	logic signed [DW-1:0] ev_s1 [3][3];      // B-A, C-A, C-B

	assign crn_in[0][0] = req.query_x;
	assign crn_in[0][1] = req.query_y;
	assign crn_in[0][2] = req.query_z;
	assign crn_in[1][0] = req.corner_a_x;
	assign crn_in[1][1] = req.corner_a_y;
	assign crn_in[1][2] = req.corner_a_z;
	assign crn_in[2][0] = req.corner_b_x;
	assign crn_in[2][1] = req.corner_b_y;
	assign crn_in[2][2] = req.corner_b_z;
	assign crn_in[3][0] = req.corner_c_x;
	assign crn_in[3][1] = req.corner_c_y;
	assign crn_in[3][2] = req.corner_c_z;

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					crn_s1[j][i] <= crn_in[j+1][i];
					fv_s1[j][i] <= DW'(crn_in[0][i]) - DW'(crn_in[j+1][i]);
				end
				ev_s1[0][i] <= DW'(crn_in[2][i]) - DW'(crn_in[1][i]);
				ev_s1[1][i] <= DW'(crn_in[3][i]) - DW'(crn_in[1][i]);
				ev_s1[2][i] <= DW'(crn_in[3][i]) - DW'(crn_in[2][i]);
			end
		end
	end

	// Stage 2: the eighteen coordinate products. Dot product m pairs edge m%2
	// (AB or AC) with the query offset m/2 (from A, B or C), so m = 0..5 gives d1..d6.
	logic signed [PW-1:0] prod_s2 [6][3];

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int f = 0; f < 3; f++) begin
				for (int e = 0; e < 2; e++) begin
					for (int i = 0; i < 3; i++) begin
						prod_s2[2*f+e][i] <= ev_s1[e][i] * fv_s1[f][i];
					end
				end
			end
		end
	end

	// Stage 3: the six dot products, exact.
	logic signed [DOTW-1:0] dot_s3 [6];
	logic [6*DOTW-1:0]      dot_vec;
	logic [6*DOTW-1:0]      dot_dly;

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int m = 0; m < 6; m++) begin
				dot_s3[m] <= DOTW'(prod_s2[m][0]) + DOTW'(prod_s2[m][1]) + DOTW'(prod_s2[m][2]);
			end
		end
	end

	always_comb begin
		for (int m = 0; m < 6; m++) begin
			dot_vec[m*DOTW +: DOTW] = dot_s3[m];
		end
	end

	// The dot products wait beside the determinant multipliers.
	cpt_dly #(
		.W(6 * DOTW),
		.N(NM)
	) u_dot_dly (
		.clk(clk),
		.en (adv),
		.d  (dot_vec),
		.q  (dot_dly)
	);

	logic signed [2*DOTW-1:0] mp [6];

	for (genvar mi = 0; mi < 6; mi++) begin : g_det_mul
		cpt_mul #(
			.AW(DOTW),
			.BW(DOTW)
		) u_mul (
			.clk(clk),
			.en (adv),
			.a  (dot_s3[MUL_A[mi]]),
			.b  (dot_s3[MUL_B[mi]]),
			.p  (mp[mi])
		);
	end

	// Stage 4: region determinants vc = d1*d4 - d3*d2, vb = d5*d2 - d1*d6, va = d3*d6 - d5*d4.
	logic signed [DOTW-1:0] dd_s4 [6];
	logic signed [DETW-1:0] vc_s4, vb_s4, va_s4;

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int m = 0; m < 6; m++) begin
				dd_s4[m] <= dot_dly[m*DOTW +: DOTW];
			end
			vc_s4 <= DETW'(mp[0]) - DETW'(mp[1]);
			vb_s4 <= DETW'(mp[2]) - DETW'(mp[3]);
			va_s4 <= DETW'(mp[4]) - DETW'(mp[5]);
		end
	end

	// Stage 5: Voronoi region search. The tests run in a fixed order and the first
	// that holds wins: vertex A, vertex B, edge AB, vertex C, edge AC, edge BC, interior.
	// The chosen region also picks the numerator(s) and the divisor for the divider.
	logic signed [DOTW:0]   d43, d56;
	logic [5:0]             d_le, d_ge;
	logic                   vc_le, vb_le, va_le;
	logic                   d43_le, d43_ge, d56_le, d56_ge;
	logic signed [NW-1:0]   rg_num0, rg_num1, rg_den;
	region_t                rg_code;
	logic                   rg_degen;
	logic signed [NW-1:0]   num0_s5, num1_s5, den_s5;
	region_t                rgn_s5;
	logic                   dgn_s5;

	always_comb begin
		d43 = (DOTW+1)'(dd_s4[3]) - (DOTW+1)'(dd_s4[2]);
		d56 = (DOTW+1)'(dd_s4[4]) - (DOTW+1)'(dd_s4[5]);
		for (int m = 0; m < 6; m++) begin
			d_ge[m] = !dd_s4[m][DOTW-1];
			d_le[m] = dd_s4[m][DOTW-1] || dd_s4[m] == '0;
		end
		vc_le = vc_s4[DETW-1] || vc_s4 == '0;
		vb_le = vb_s4[DETW-1] || vb_s4 == '0;
		va_le = va_s4[DETW-1] || va_s4 == '0;
		d43_ge = !d43[DOTW];
		d43_le = d43[DOTW] || d43 == '0;
		d56_ge = !d56[DOTW];
		d56_le = d56[DOTW] || d56 == '0;

		rg_num0 = '0;
		rg_num1 = '0;
		rg_den = '0;
		if (d_le[0] && d_le[1]) begin
			rg_code = RG_A;
		end else if (d_ge[2] && d43_le) begin
			rg_code = RG_B;
		end else if (vc_le && d_ge[0] && d_le[2]) begin
			rg_code = RG_AB;
			rg_num0 = NW'(dd_s4[0]);
			rg_den = NW'(dd_s4[0]) - NW'(dd_s4[2]);
		end else if (d_ge[5] && d56_le) begin
			rg_code = RG_C;
		end else if (vb_le && d_ge[1] && d_le[5]) begin
			rg_code = RG_AC;
			rg_num0 = NW'(dd_s4[1]);
			rg_den = NW'(dd_s4[1]) - NW'(dd_s4[5]);
		end else if (va_le && d43_ge && d56_ge) begin
			rg_code = RG_BC;
			rg_num0 = NW'(d43);
			rg_den = NW'(d43) + NW'(d56);
		end else begin
			rg_code = RG_IN;
			rg_num0 = NW'(vb_s4);
			rg_num1 = NW'(vc_s4);
			rg_den = NW'(va_s4) + NW'(vb_s4) + NW'(vc_s4);
		end
		// A region that divides and finds no positive divisor falls back to corner A.
		rg_degen = !(rg_code == RG_A || rg_code == RG_B || rg_code == RG_C)
			&& (rg_den[NW-1] || rg_den == '0);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			num0_s5 <= rg_num0;
			num1_s5 <= rg_num1;
			den_s5 <= rg_den;
			rgn_s5 <= rg_code;
			dgn_s5 <= rg_degen;
		end
	end

	// Two dividers share the divisor; the second one only matters in the interior.
	weight_t q0, q1;

	cpt_div #(
		.NW(NW)
	) u_div0 (
		.clk(clk),
		.en (adv),
		.num(num0_s5),
		.den(den_s5),
		.q  (q0)
	);

	cpt_div #(
		.NW(NW)
	) u_div1 (
		.clk(clk),
		.en (adv),
		.num(num1_s5),
		.den(den_s5),
		.q  (q1)
	);

	logic [REGION_W:0] rgd_dly;

	cpt_dly #(
		.W(REGION_W + 1),
		.N(DIV_LAT)
	) u_rgn_dly (
		.clk(clk),
		.en (adv),
		.d  ({rgn_s5, dgn_s5}),
		.q  (rgd_dly)
	);

	// Corners and edges ride alongside until the weights are known.
	logic [SW-1:0]        side_in, side_out;
	logic signed [CB-1:0] sd_crn [3][3];
	logic signed [DW-1:0] sd_ev [3][3];

	always_comb begin
		for (int j = 0; j < 3; j++) begin
			for (int i = 0; i < 3; i++) begin
				side_in[(j*3+i)*CB +: CB] = crn_s1[j][i];
				side_in[9*CB + (j*3+i)*DW +: DW] = ev_s1[j][i];
				sd_crn[j][i] = side_out[(j*3+i)*CB +: CB];
				sd_ev[j][i] = side_out[9*CB + (j*3+i)*DW +: DW];
			end
		end
	end

	cpt_dly #(
		.W(SW),
		.N(SIDE_N)
	) u_side_dly (
		.clk(clk),
		.en (adv),
		.d  (side_in),
		.q  (side_out)
	);

	// Stage 6: weights and blend operands. The nearest point is always
	// base + floor((e1*w1 + e2*w2) / 2^30), which covers corners, edges and the interior.
	region_t              sel_rgn;
	logic                 sel_dgn;
	logic [WEIGHT_W:0]    wsum;
	weight_t              wc_fix;
	weight_t              sel_wa, sel_wb, sel_wc, sel_w1, sel_w2;
	logic signed [CB-1:0] sel_base [3];
	logic signed [DW-1:0] sel_e1 [3];
	logic signed [DW-1:0] sel_e2 [3];

	weight_t              wa_s6, wb_s6, wc_s6, w1_s6, w2_s6;
	region_t              rgn_s6;
	logic                 dgn_s6;
	logic signed [CB-1:0] base_s6 [3];
	logic signed [DW-1:0] e1_s6 [3];
	logic signed [DW-1:0] e2_s6 [3];

	assign sel_rgn = rgd_dly[REGION_W:1];
	assign sel_dgn = rgd_dly[0];
	assign wsum = (WEIGHT_W+1)'(q0) + (WEIGHT_W+1)'(q1);
	assign wc_fix = (wsum > (WEIGHT_W+1)'(W_ONE)) ? W_ONE - q0 : q1;

	always_comb begin
		sel_wa = W_ONE;
		sel_wb = '0;
		sel_wc = '0;
		sel_w1 = '0;
		sel_w2 = '0;
		for (int i = 0; i < 3; i++) begin
			sel_base[i] = sd_crn[0][i];
			sel_e1[i] = sd_ev[0][i];
			sel_e2[i] = sd_ev[1][i];
		end
		if (!sel_dgn) begin
			case (sel_rgn)
				RG_B: begin
					sel_wa = '0;
					sel_wb = W_ONE;
					for (int i = 0; i < 3; i++) sel_base[i] = sd_crn[1][i];
				end
				RG_C: begin
					sel_wa = '0;
					sel_wc = W_ONE;
					for (int i = 0; i < 3; i++) sel_base[i] = sd_crn[2][i];
				end
				RG_AB: begin
					sel_wb = q0;
					sel_wa = W_ONE - q0;
					sel_w1 = q0;
				end
				RG_AC: begin
					sel_wc = q0;
					sel_wa = W_ONE - q0;
					sel_w1 = q0;
					for (int i = 0; i < 3; i++) sel_e1[i] = sd_ev[1][i];
				end
				RG_BC: begin
					sel_wa = '0;
					sel_wc = q0;
					sel_wb = W_ONE - q0;
					sel_w1 = q0;
					for (int i = 0; i < 3; i++) begin
						sel_base[i] = sd_crn[1][i];
						sel_e1[i] = sd_ev[2][i];
					end
				end
				RG_IN: begin
					sel_wb = q0;
					sel_wc = wc_fix;
					sel_wa = W_ONE - q0 - wc_fix;
					sel_w1 = q0;
					sel_w2 = wc_fix;
				end
				default: begin
					// Vertex A keeps the defaults.
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			wa_s6 <= sel_wa;
			wb_s6 <= sel_wb;
			wc_s6 <= sel_wc;
			w1_s6 <= sel_w1;
			w2_s6 <= sel_w2;
			rgn_s6 <= sel_rgn;
			dgn_s6 <= sel_dgn;
			for (int i = 0; i < 3; i++) begin
				base_s6[i] <= sel_base[i];
				e1_s6[i] <= sel_e1[i];
				e2_s6[i] <= sel_e2[i];
			end
		end
	end

	// Stage 7: edge times weight.
	logic signed [MW-1:0] m1_s7 [3];
	logic signed [MW-1:0] m2_s7 [3];
	logic signed [CB-1:0] base_s7 [3];
	weight_t              wa_s7, wb_s7, wc_s7;
	region_t              rgn_s7;
	logic                 dgn_s7;

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				m1_s7[i] <= e1_s6[i] * $signed({1'b0, w1_s6});
				m2_s7[i] <= e2_s6[i] * $signed({1'b0, w2_s6});
				base_s7[i] <= base_s6[i];
			end
			wa_s7 <= wa_s6;
			wb_s7 <= wb_s6;
			wc_s7 <= wc_s6;
			rgn_s7 <= rgn_s6;
			dgn_s7 <= dgn_s6;
		end
	end

	// Stage 8: floor of the blend sum by 2^30, added to the base, wrapped to the
	// coordinate width. This is the output register.
	logic signed [MW:0]   bsum [3];
	logic signed [CB-1:0] near_s8 [3];
	weight_t              wa_s8, wb_s8, wc_s8;
	region_t              rgn_s8;
	logic                 dgn_s8;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			bsum[i] = (MW+1)'(m1_s7[i]) + (MW+1)'(m2_s7[i]);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				near_s8[i] <= base_s7[i] + CB'(bsum[i] >>> Q_FRAC);
			end
			wa_s8 <= wa_s7;
			wb_s8 <= wb_s7;
			wc_s8 <= wc_s7;
			rgn_s8 <= rgn_s7;
			dgn_s8 <= dgn_s7;
		end
	end

	assign rsp.near_x = near_s8[0];
	assign rsp.near_y = near_s8[1];
	assign rsp.near_z = near_s8[2];
	assign rsp.weight_a = wa_s8;
	assign rsp.weight_b = wb_s8;
	assign rsp.weight_c = wc_s8;
	assign rsp.region = rgn_s8;
	assign rsp.degenerate = dgn_s8;

endmodule

[rtl/cpt_chk.sv]
`timescale 1ns / 1ps
module cpt_chk
	import cpt_pkg::*;
(
	input logic    clk,
	input logic    arst_n,
	input logic    in_ready,
	input logic    out_valid,
	input logic    out_ready,
	input weight_t weight_a,
	input weight_t weight_b,
	input weight_t weight_c,
	input region_t region,
	input logic    degenerate
);

	// A result that is not taken stays put.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(weight_a) && $stable(weight_b)
			&& $stable(weight_c) && $stable(region) && $stable(degenerate))
		else $error("result changed while stalled");

	// With the output register empty the pipeline always moves.
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with an empty output");

	// The three weights always add up to one.
	a_wsum: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (32'(weight_a) + 32'(weight_b) + 32'(weight_c)) == 32'(W_ONE))
		else $error("weights do not sum to one");

	// The fallback only happens in a region that divides, and it returns corner A.
	a_degen: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && degenerate |-> weight_a == W_ONE && (region == RG_AB
			|| region == RG_AC || region == RG_BC || region == RG_IN))
		else $error("degenerate result in a vertex region");

	// Vertex B gives its corner the whole weight.
	a_vert: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && region == RG_B |-> weight_b == W_ONE && !degenerate)
		else $error("vertex B result with split weights");

endmodule

bind closest_point_on_triangle_top cpt_chk u_cpt_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (req.ready),
	.out_valid (rsp.valid),
	.out_ready (rsp.ready),
	.weight_a  (rsp.weight_a),
	.weight_b  (rsp.weight_b),
	.weight_c  (rsp.weight_c),
	.region    (rsp.region),
	.degenerate(rsp.degenerate)
);
